### hdl/bdt_pkg.sv
`default_nettype none
package bdt_pkg;
  localparam int Entries = 8;
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);
  localparam logic [7:0] NoEntry = 8'hFF;

  typedef enum logic [3:0] {
    OP_FIND = 4'd0, OP_ADD = 4'd1, OP_REMOVE = 4'd2, OP_CLEAR = 4'd3,
    OP_CONN = 4'd4, OP_SET_ACTIVE = 4'd5, OP_SWITCH = 4'd6, OP_STATE = 4'd7,
    OP_FIND_CONN = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RANGE = 3'd1, ST_NOT_FOUND = 3'd2, ST_FULL = 3'd3,
    ST_NO_CONN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_ADDED = 3'd1, EV_REMOVED = 3'd2, EV_CONNECTED = 3'd3,
    EV_DISCONNECTED = 3'd4, EV_ACTIVE = 3'd5, EV_CLEARED = 3'd6
  } event_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [47:0] mac_address;
    logic [7:0]  address_type;
    logic [3:0]  device_kind;
    logic [7:0]  device_index;
    logic [7:0]  connection_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] result_index;
    logic [2:0] event_code;
    logic [7:0] event_index;
    logic [7:0] active_index;
    logic [6:0] linked_count;
    logic       entry_linked;
    logic       last_of_run;
  } rsp_t;
endpackage
`default_nettype wire

### hdl/bdt_if.sv
`default_nettype none
interface bdt_cmd_if import bdt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdt_rsp_if import bdt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/bonded_device_table_core.sv
// Bonded device table of Entries peers. One command is taken at a time; the
// sequencer walks the table one entry per cycle through a single shared
// address comparator to search it, executes the command, then walks it again
// to count linked entries. Every operation passes through the same states,
// S_SCAN, S_EXEC and S_SCAN2, before the first result item is offered. Up to
// two result items follow each command, the last flagged by last_of_run;
// ready stays low until the final item is taken.
`default_nettype none
module bonded_device_table_core import bdt_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  bdt_cmd_if.sink  cmd,
  bdt_rsp_if.source rsp
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SCAN2, S_EXEC, S_OUT1, S_OUT2} state_t;

  state_t state;
  cmd_t c;
  logic [IdxW:0] i;
  logic [Entries-1:0] valid;
  logic [7:0] link [Entries];
  logic [47:0] addr [Entries];
  logic [7:0] atype [Entries];
  logic [3:0] kind [Entries];
  logic [7:0] active;
  logic [7:0] hit, hitc, freei, first, nxt, low_other;
  logic seen;
  logic [CntW-1:0] nconn;
  logic [2:0] status;
  logic [7:0] result;
  logic [2:0] ev0, ev1;
  logic [7:0] ei0, ei1;
  logic two, isconn;

  logic [IdxW-1:0] ii;
  logic linked_i, match_i, in_range;
  logic [IdxW-1:0] di;

  assign ii = i[IdxW-1:0];
  assign di = c.device_index[IdxW-1:0];
  assign in_range = c.device_index < 8'(Entries);
  assign linked_i = valid[ii] && link[ii] != NoEntry;
  assign match_i = valid[ii] && addr[ii] == c.mac_address;

  assign cmd.ready = state == S_IDLE;
  assign rsp.valid = state == S_OUT1 || state == S_OUT2;

  always_comb begin
    rsp.data.status = status;
    rsp.data.result_index = result;
    rsp.data.active_index = active;
    rsp.data.linked_count = 7'(nconn);
    rsp.data.entry_linked = isconn;
    if (state == S_OUT2) begin
      rsp.data.event_code = ev1;
      rsp.data.event_index = ei1;
      rsp.data.last_of_run = 1'b1;
    end else begin
      rsp.data.event_code = ev0;
      rsp.data.event_index = ei0;
      rsp.data.last_of_run = !two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      active <= NoEntry;
      for (int k = 0; k < Entries; k++) link[k] <= NoEntry;
    end else begin
      case (state)
        S_IDLE: if (cmd.valid) begin
          c <= cmd.data;
          i <= '0;
          hit <= NoEntry; hitc <= NoEntry; freei <= NoEntry;
          first <= NoEntry; nxt <= NoEntry; seen <= 1'b0; low_other <= NoEntry;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (i == (IdxW+1)'(Entries)) begin
            state <= S_EXEC;
          end else begin
            if (match_i && hit == NoEntry) hit <= 8'(ii);
            if (match_i && linked_i && hitc == NoEntry) hitc <= 8'(ii);
            if (!valid[ii] && freei == NoEntry) freei <= 8'(ii);
            if (linked_i) begin
              if (first == NoEntry) first <= 8'(ii);
              if (seen && nxt == NoEntry) nxt <= 8'(ii);
              if (8'(ii) == active) seen <= 1'b1;
              if (8'(ii) != c.device_index && low_other == NoEntry) low_other <= 8'(ii);
            end
            i <= i + 1'b1;
          end
        end
        S_EXEC: begin
          status <= ST_OK; result <= NoEntry; isconn <= 1'b0;
          ev0 <= EV_NONE; ei0 <= NoEntry; ev1 <= EV_NONE; ei1 <= NoEntry; two <= 1'b0;
          case (c.op)
            OP_FIND: begin
              result <= hit;
              if (hit == NoEntry) status <= ST_NOT_FOUND;
            end
            OP_ADD: begin
              if (hit != NoEntry) begin
                result <= hit;
                atype[hit[IdxW-1:0]] <= c.address_type;
                kind[hit[IdxW-1:0]] <= c.device_kind;
              end else if (freei == NoEntry) begin
                status <= ST_FULL;
              end else begin
                result <= freei;
                valid[freei[IdxW-1:0]] <= 1'b1;
                addr[freei[IdxW-1:0]] <= c.mac_address;
                link[freei[IdxW-1:0]] <= NoEntry;
                atype[freei[IdxW-1:0]] <= c.address_type;
                kind[freei[IdxW-1:0]] <= c.device_kind;
                ev0 <= EV_ADDED; ei0 <= freei;
              end
            end
            OP_REMOVE: begin
              if (!in_range) status <= ST_RANGE;
              else if (!valid[di]) status <= ST_NOT_FOUND;
              else begin
                valid[di] <= 1'b0;
                link[di] <= NoEntry;
                if (active == c.device_index) active <= NoEntry;
                ev0 <= EV_REMOVED; ei0 <= c.device_index;
              end
            end
            OP_CLEAR: begin
              valid <= '0;
              for (int k = 0; k < Entries; k++) link[k] <= NoEntry;
              active <= NoEntry;
              ev0 <= EV_CLEARED;
            end
            OP_CONN: begin
              if (!in_range) status <= ST_RANGE;
              else if (!valid[di]) status <= ST_NOT_FOUND;
              else begin
                link[di] <= c.connection_index;
                if (c.connection_index != NoEntry && link[di] == NoEntry) begin
                  ev0 <= EV_CONNECTED; ei0 <= c.device_index;
                end else if (c.connection_index == NoEntry && link[di] != NoEntry) begin
                  if (active == c.device_index) begin
                    active <= low_other;
                    if (low_other != NoEntry) begin
                      ev0 <= EV_ACTIVE; ei0 <= low_other;
                      ev1 <= EV_DISCONNECTED; ei1 <= c.device_index; two <= 1'b1;
                    end else begin
                      ev0 <= EV_DISCONNECTED; ei0 <= c.device_index;
                    end
                  end else begin
                    ev0 <= EV_DISCONNECTED; ei0 <= c.device_index;
                  end
                end
              end
            end
            OP_SET_ACTIVE: begin
              if (!in_range && c.device_index != NoEntry) status <= ST_RANGE;
              else if (c.device_index != NoEntry && !valid[di]) status <= ST_NOT_FOUND;
              else begin
                result <= c.device_index;
                if (active != c.device_index) begin
                  active <= c.device_index;
                  ev0 <= EV_ACTIVE; ei0 <= c.device_index;
                end
              end
            end
            OP_SWITCH: begin
              if (first == NoEntry) status <= ST_NO_CONN;
              else begin
                result <= (nxt == NoEntry) ? first : nxt;
                if (nxt != NoEntry || first != active) begin
                  active <= (nxt == NoEntry) ? first : nxt;
                  ev0 <= EV_ACTIVE; ei0 <= (nxt == NoEntry) ? first : nxt;
                end
              end
            end
            OP_STATE: begin
              if (!in_range) status <= ST_RANGE;
              else if (!valid[di]) status <= ST_NOT_FOUND;
              else isconn <= link[di] != NoEntry;
            end
            OP_FIND_CONN: begin
              if (c.mac_address != '0 && hitc != NoEntry) result <= hitc;
              else status <= ST_NOT_FOUND;
            end
            default: ;
          endcase
          i <= '0;
          nconn <= '0;
          state <= S_SCAN2;
        end
        S_SCAN2: begin
          if (i == (IdxW+1)'(Entries)) state <= S_OUT1;
          else begin
            if (linked_i) nconn <= nconn + 1'b1;
            i <= i + 1'b1;
          end
        end
        S_OUT1: if (rsp.ready) state <= two ? S_OUT2 : S_IDLE;
        S_OUT2: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
